>>> hw/rtl/lexicographic_permutation_stepper_core_macros.svh
// Assertion macros used by the permutation stepper checker.
`ifndef LEXICOGRAPHIC_PERMUTATION_STEPPER_CORE_MACROS_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEPPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lps_pkg.sv
// Shared types, constants and helpers of the permutation stepper.
package lps_pkg;

    localparam int MAX_LEN = 16;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = 5;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_IDENT = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_PREV  = 2'd3
    } lps_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDENT,
        ST_SCAN_P,
        ST_SCAN_L,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_REV_RDA,
        ST_REV_RDB,
        ST_REV_WA,
        ST_REV_WB,
        ST_EMIT_RD,
        ST_EMIT_LD
    } lps_state_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]         raddr;
    } lps_ram_req_t;

    // True when lo and hi are in strict order for the given direction.
    function automatic logic ordered(input logic fwd, input logic signed [DATA_W-1:0] lo,
                                     input logic signed [DATA_W-1:0] hi);
        ordered = fwd ? (lo < hi) : (lo > hi);
    endfunction

endpackage

>>> hw/rtl/lps_ram.sv
// Element store: one write port and one registered read port.
module lps_ram (
    input  logic                             clk,
    input  lps_pkg::lps_ram_req_t            req,
    output logic signed [lps_pkg::DATA_W-1:0] rdata
);

    logic signed [lps_pkg::DATA_W-1:0] mem [lps_pkg::MAX_LEN];
    logic signed [lps_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lps_ctrl.sv
// Command sequencer: loads and fills, scans, swaps, reverses and streams the element store.
module lps_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lps_pkg::IDX_W-1:0]         n_last,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lps_pkg::CMD_W-1:0]         cmd,
    input  logic [3:0]                        index,
    input  logic signed [lps_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        position,
    output logic signed [lps_pkg::DATA_W-1:0] element,
    output logic                              last,
    output logic                              advanced,
    output logic                              idle,
    output lps_pkg::lps_ram_req_t             ram_req,
    input  logic signed [lps_pkg::DATA_W-1:0] ram_rdata
);

    lps_pkg::lps_state_t state_reg, state_next;

    logic [lps_pkg::IDX_W-1:0]         rd_idx_reg;
    logic [lps_pkg::IDX_W-1:0]         k_reg, k_next;
    logic [lps_pkg::IDX_W-1:0]         r_reg, r_next;
    logic signed [lps_pkg::DATA_W-1:0] hold_reg, hold_next;
    logic signed [lps_pkg::DATA_W-1:0] piv_reg, piv_next;
    logic                              have_prev_reg, have_prev_next;
    logic                              fwd_reg, fwd_next;
    logic                              adv_reg, adv_next;

    logic                              out_valid_reg, out_valid_next;
    logic [3:0]                        pos_reg;
    logic signed [lps_pkg::DATA_W-1:0] elem_reg;
    logic                              last_reg;
    logic                              adv_out_reg;
    logic                              out_load;

    logic step_ok;
    logic part_ok;
    logic at_zero;
    logic emit_go;
    logic k_last;
    logic rev_more;
    logic in_take;

    assign in_take  = in_valid && (state_reg == lps_pkg::ST_IDLE);
    assign step_ok  = lps_pkg::ordered(fwd_reg, ram_rdata, hold_reg);
    assign part_ok  = lps_pkg::ordered(fwd_reg, piv_reg, ram_rdata);
    assign at_zero  = (rd_idx_reg == '0);
    assign emit_go  = !out_valid_reg || !out_stall;
    assign k_last   = (k_reg == n_last);
    assign rev_more = (k_reg < r_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (cmd)
                        lps_pkg::CMD_IDENT: state_next = lps_pkg::ST_IDENT;
                        lps_pkg::CMD_NEXT,
                        lps_pkg::CMD_PREV:  state_next = lps_pkg::ST_SCAN_P;
                        default:            state_next = lps_pkg::ST_IDLE;
                    endcase
                end
            end
            lps_pkg::ST_IDENT:
            begin
                if (k_last)
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            lps_pkg::ST_SCAN_P:
            begin
                if (have_prev_reg && step_ok)
                begin
                    state_next = lps_pkg::ST_SCAN_L;
                end
                else if (at_zero)
                begin
                    state_next = lps_pkg::ST_EMIT_RD;
                end
            end
            lps_pkg::ST_SCAN_L:
            begin
                if (part_ok)
                begin
                    state_next = lps_pkg::ST_SWAP_A;
                end
            end
            lps_pkg::ST_SWAP_A:  state_next = lps_pkg::ST_SWAP_B;
            lps_pkg::ST_SWAP_B:  state_next = lps_pkg::ST_REV_RDA;
            lps_pkg::ST_REV_RDA:
            begin
                state_next = rev_more ? lps_pkg::ST_REV_RDB : lps_pkg::ST_EMIT_RD;
            end
            lps_pkg::ST_REV_RDB: state_next = lps_pkg::ST_REV_WA;
            lps_pkg::ST_REV_WA:  state_next = lps_pkg::ST_REV_WB;
            lps_pkg::ST_REV_WB:  state_next = lps_pkg::ST_REV_RDA;
            lps_pkg::ST_EMIT_RD:
            begin
                if (emit_go)
                begin
                    state_next = lps_pkg::ST_EMIT_LD;
                end
            end
            lps_pkg::ST_EMIT_LD:
            begin
                state_next = k_last ? lps_pkg::ST_IDLE : lps_pkg::ST_EMIT_RD;
            end
            default: state_next = lps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next         = k_reg;
        r_next         = r_reg;
        hold_next      = hold_reg;
        piv_next       = piv_reg;
        have_prev_next = have_prev_reg;
        fwd_next       = fwd_reg;
        adv_next       = adv_reg;
        out_load       = 1'b0;
        ram_req.we     = 1'b0;
        ram_req.waddr  = k_reg;
        ram_req.wdata  = hold_reg;
        ram_req.raddr  = rd_idx_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                ram_req.raddr = n_last;
                if (in_take)
                begin
                    fwd_next       = (cmd == lps_pkg::CMD_NEXT);
                    k_next         = '0;
                    have_prev_next = 1'b0;
                    if ((cmd == lps_pkg::CMD_LOAD) &&
                        (lps_pkg::LEN_W'(index) < lps_pkg::LEN_W'(lps_pkg::MAX_LEN)))
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = lps_pkg::IDX_W'(index);
                        ram_req.wdata = value;
                    end
                end
            end
            lps_pkg::ST_IDENT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = k_reg;
                ram_req.wdata = lps_pkg::DATA_W'(k_reg);
                k_next        = k_reg + 1'b1;
            end
            lps_pkg::ST_SCAN_P:
            begin
                hold_next      = ram_rdata;
                have_prev_next = 1'b1;
                if (have_prev_reg && step_ok)
                begin
                    piv_next      = ram_rdata;
                    k_next        = rd_idx_reg;
                    ram_req.raddr = n_last;
                end
                else if (at_zero)
                begin
                    adv_next = 1'b0;
                    k_next   = '0;
                end
                else
                begin
                    ram_req.raddr = rd_idx_reg - 1'b1;
                end
            end
            lps_pkg::ST_SCAN_L:
            begin
                if (part_ok)
                begin
                    hold_next = ram_rdata;
                    r_next    = rd_idx_reg;
                end
                else
                begin
                    ram_req.raddr = rd_idx_reg - 1'b1;
                end
            end
            lps_pkg::ST_SWAP_A:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = k_reg;
                ram_req.wdata = hold_reg;
            end
            lps_pkg::ST_SWAP_B:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_reg;
                ram_req.wdata = piv_reg;
                k_next        = k_reg + 1'b1;
                r_next        = n_last;
                adv_next      = 1'b1;
            end
            lps_pkg::ST_REV_RDA:
            begin
                if (rev_more)
                begin
                    ram_req.raddr = k_reg;
                end
                else
                begin
                    k_next = '0;
                end
            end
            lps_pkg::ST_REV_RDB:
            begin
                ram_req.raddr = r_reg;
                hold_next     = ram_rdata;
            end
            lps_pkg::ST_REV_WA:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = k_reg;
                ram_req.wdata = ram_rdata;
            end
            lps_pkg::ST_REV_WB:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_reg;
                ram_req.wdata = hold_reg;
                k_next        = k_reg + 1'b1;
                r_next        = r_reg - 1'b1;
            end
            lps_pkg::ST_EMIT_RD:
            begin
                if (emit_go)
                begin
                    ram_req.raddr = k_reg;
                end
            end
            lps_pkg::ST_EMIT_LD:
            begin
                out_load = 1'b1;
                k_next   = k_reg + 1'b1;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            k_reg         <= '0;
            r_reg         <= '0;
            rd_idx_reg    <= '0;
            fwd_reg       <= 1'b0;
            adv_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_prev_reg <= have_prev_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            rd_idx_reg    <= ram_req.raddr;
            fwd_reg       <= fwd_next;
            adv_reg       <= adv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        piv_reg  <= piv_next;
        if (out_load)
        begin
            pos_reg     <= 4'(k_reg);
            elem_reg    <= ram_rdata;
            last_reg    <= k_last;
            adv_out_reg <= adv_reg;
        end
    end

    assign in_stall  = (state_reg != lps_pkg::ST_IDLE);
    assign idle      = (state_reg == lps_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = pos_reg;
    assign element   = elem_reg;
    assign last      = last_reg;
    assign advanced  = adv_out_reg;

endmodule

>>> hw/rtl/lexicographic_permutation_stepper_core.sv
// Top level of the lexicographic permutation stepper with its length register.
//
// The block keeps up to 16 signed 32-bit elements in a single-port-read memory and
// steps them to the next or previous lexicographic permutation. A load writes one
// entry and leaves the block idle; an identity fill writes entries 0 to n - 1. A
// step reads the store one entry per cycle to find the pivot and the swap partner,
// writes the swap in SWAP_A and SWAP_B, reverses the suffix pair by pair through
// REV_RDA, REV_RDB, REV_WA and REV_WB, then streams n beats, each read in EMIT_RD
// (which waits while the output stalls) and loaded in EMIT_LD. The store's one
// read port and one write port serve every access. New commands are taken only
// between steps, while the last beat of a step may still wait at the output. The
// length register is written while no command is in progress.
module lexicographic_permutation_stepper_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lps_pkg::CMD_W-1:0]         cmd,
    input  logic [3:0]                        index,
    input  logic signed [lps_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        position,
    output logic signed [lps_pkg::DATA_W-1:0] element,
    output logic                              last,
    output logic                              advanced,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lps_pkg::LEN_W-1:0]         cfg_data
);

    logic [lps_pkg::LEN_W-1:0]         len_reg;
    logic [lps_pkg::LEN_W-1:0]         eff_len;
    logic [lps_pkg::IDX_W-1:0]         n_last;
    logic                              idle;
    lps_pkg::lps_ram_req_t             ram_req;
    logic signed [lps_pkg::DATA_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= lps_pkg::LEN_W'(lps_pkg::MAX_LEN);
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = lps_pkg::LEN_W'(1);
        end
        else if (len_reg > lps_pkg::LEN_W'(lps_pkg::MAX_LEN))
        begin
            eff_len = lps_pkg::LEN_W'(lps_pkg::MAX_LEN);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign n_last    = lps_pkg::IDX_W'(eff_len - 1'b1);
    assign cfg_ready = idle;

    lps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_last    (n_last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .element   (element),
        .last      (last),
        .advanced  (advanced),
        .idle      (idle),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    lps_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

>>> hw/rtl/lps_chk.sv
// Port-level checker of the permutation stepper and its bind to the top level.
`include "lexicographic_permutation_stepper_core_macros.svh"

module lps_chk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [lps_pkg::CMD_W-1:0]         cmd,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [3:0]                        position,
    input  logic signed [lps_pkg::DATA_W-1:0] element,
    input  logic                              last,
    input  logic                              advanced,
    input  logic                              cfg_ready
);

    logic in_beat;

    assign in_beat = in_valid && !in_stall;

    `LPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({position, element, last, advanced}), "stalled beat changed")
    `LPS_ASSERT_SAME(a_top_last, out_valid && (position == 4'(lps_pkg::MAX_LEN - 1)), last, "final position without last")
    `LPS_ASSERT_SAME(a_cfg_idle, cfg_ready, !in_stall, "config ready while a command runs")
    `LPS_ASSERT_NEXT(a_load_one, in_beat && (cmd == lps_pkg::CMD_LOAD), !in_stall, "load did not finish in one cycle")
    `LPS_ASSERT_NEXT(a_step_busy, in_beat && ((cmd == lps_pkg::CMD_NEXT) || (cmd == lps_pkg::CMD_PREV)), in_stall, "step did not hold off input")

endmodule

bind lexicographic_permutation_stepper_core lps_chk u_lps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .element   (element),
    .last      (last),
    .advanced  (advanced),
    .cfg_ready (cfg_ready)
);

>>> sim/tb_lexicographic_permutation_stepper_core.sv
// Self-checking testbench of the lexicographic permutation stepper core.
module tb_lexicographic_permutation_stepper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_CYCLES = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int PRINT_CAP    = 200;

    typedef struct {
        logic [3:0]                        position;
        logic signed [lps_pkg::DATA_W-1:0] element;
        logic                              last;
        logic                              advanced;
    } perm_beat_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    lps_pkg::lps_cmd_t                 cmd       = lps_pkg::CMD_LOAD;
    logic [3:0]                        index     = '0;
    logic signed [lps_pkg::DATA_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [3:0]                        position;
    logic signed [lps_pkg::DATA_W-1:0] element;
    logic                              last;
    logic                              advanced;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [lps_pkg::LEN_W-1:0]         cfg_data  = '0;

    logic signed [lps_pkg::DATA_W-1:0] seq_model [lps_pkg::MAX_LEN];
    logic [lps_pkg::LEN_W-1:0]         len_model = 5'd16;
    perm_beat_t                        pending_beats [$];
    int                                mismatches  = 0;
    int                                tx_idle_pct = 0;
    int                                rx_idle_pct = 0;
    int                                hold_cycles = 0;

    lexicographic_permutation_stepper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .element   (element),
        .last      (last),
        .advanced  (advanced),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic int active_len();
        int n;
        n = len_model;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > lps_pkg::MAX_LEN)
        begin
            n = lps_pkg::MAX_LEN;
        end
        return n;
    endfunction

    function automatic void swap_model(input int p, input int q);
        logic signed [lps_pkg::DATA_W-1:0] t;
        t            = seq_model[p];
        seq_model[p] = seq_model[q];
        seq_model[q] = t;
    endfunction

    function automatic bit permute_model(input int n, input bit fwd);
        int k;
        int i;
        int l;
        bit found;
        k     = n - 1;
        found = 1'b0;
        while (k > 0 && !found)
        begin
            if (fwd ? (seq_model[k-1] < seq_model[k]) : (seq_model[k-1] > seq_model[k]))
            begin
                found = 1'b1;
            end
            else
            begin
                k--;
            end
        end
        if (!found)
        begin
            return 1'b0;
        end
        i     = k - 1;
        l     = n - 1;
        found = 1'b0;
        while (l > i && !found)
        begin
            if (fwd ? (seq_model[l] > seq_model[i]) : (seq_model[l] < seq_model[i]))
            begin
                found = 1'b1;
            end
            else
            begin
                l--;
            end
        end
        swap_model(i, l);
        l = n - 1;
        while (k < l)
        begin
            swap_model(k, l);
            k++;
            l--;
        end
        return 1'b1;
    endfunction

    function automatic void apply_command(input lps_pkg::lps_cmd_t c, input logic [3:0] idx,
                                          input logic signed [lps_pkg::DATA_W-1:0] v);
        int         n;
        bit         adv;
        perm_beat_t b;
        n = active_len();
        case (c)
            lps_pkg::CMD_LOAD:
            begin
                seq_model[idx] = v;
            end
            lps_pkg::CMD_IDENT:
            begin
                for (int p = 0; p < n; p++)
                begin
                    seq_model[p] = lps_pkg::DATA_W'(p);
                end
            end
            default:
            begin
                adv = permute_model(n, c == lps_pkg::CMD_NEXT);
                for (int p = 0; p < n; p++)
                begin
                    b.position = p[3:0];
                    b.element  = seq_model[p];
                    b.last     = (p == n - 1);
                    b.advanced = adv;
                    pending_beats.push_back(b);
                end
            end
        endcase
    endfunction

    task automatic push_command(input lps_pkg::lps_cmd_t c, input logic [3:0] idx,
                                input logic signed [lps_pkg::DATA_W-1:0] v);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        index    <= idx;
        value    <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        apply_command(c, idx, v);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input logic [lps_pkg::LEN_W-1:0] len);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_model = len;
    endtask

    function automatic logic signed [lps_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(4, 0))
            0:       return $urandom_range(3, 0);
            1:       return $signed($urandom_range(4, 0)) - 2;
            2:       return ($urandom_range(1, 0) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [lps_pkg::LEN_W-1:0] pick_length();
        case ($urandom_range(9, 0))
            0:       return 5'd1;
            1:       return 5'd2;
            2, 3:    return 5'd3;
            4:       return 5'd4;
            5:       return 5'd5;
            6:       return 5'd16;
            7:       return ($urandom_range(1, 0) != 0) ? 5'd0 : 5'd31;
            8:       return lps_pkg::LEN_W'($urandom_range(16, 1));
            default: return 5'd6;
        endcase
    endfunction

    task automatic test_identity_and_extremes();
        push_command(lps_pkg::CMD_IDENT, 4'd0, 0);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        push_command(lps_pkg::CMD_LOAD, 4'd0, 32'sh8000_0000);
        push_command(lps_pkg::CMD_LOAD, 4'd15, 32'sh7FFF_FFFF);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
        push_command(lps_pkg::CMD_LOAD, 4'd7, -1);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
    endtask

    task automatic test_length_corners();
        set_length(5'd1);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
        set_length(5'd0);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        set_length(5'd31);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
        set_length(5'd3);
        push_command(lps_pkg::CMD_LOAD, 4'd10, 32'sh5A5A_A5A5);
        push_command(lps_pkg::CMD_IDENT, 4'd0, 0);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        set_length(5'd16);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
    endtask

    task automatic test_repeated_values();
        set_length(5'd4);
        push_command(lps_pkg::CMD_LOAD, 4'd0, 3);
        push_command(lps_pkg::CMD_LOAD, 4'd1, 1);
        push_command(lps_pkg::CMD_LOAD, 4'd2, 1);
        push_command(lps_pkg::CMD_LOAD, 4'd3, 0);
        push_command(lps_pkg::CMD_NEXT, 4'd0, 0);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
        push_command(lps_pkg::CMD_PREV, 4'd0, 0);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int budget);
        int                left;
        int                n;
        int                r;
        lps_pkg::lps_cmd_t c;
        left        = budget;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (left > 0)
        begin
            set_length(pick_length());
            n = active_len();
            if ($urandom_range(2, 0) == 0)
            begin
                push_command(lps_pkg::CMD_IDENT, 4'($urandom_range(15, 0)), $urandom);
                left--;
            end
            else
            begin
                for (int p = 0; p < n; p++)
                begin
                    push_command(lps_pkg::CMD_LOAD, p[3:0], rand_value());
                end
                left -= n;
            end
            repeat ($urandom_range(12, 4))
            begin
                r = $urandom_range(99, 0);
                if (r < 10)
                begin
                    push_command(lps_pkg::CMD_LOAD, 4'($urandom_range(15, 0)), rand_value());
                end
                else
                begin
                    c = (r < 14) ? lps_pkg::CMD_IDENT :
                        ((r < 72) ? lps_pkg::CMD_NEXT : lps_pkg::CMD_PREV);
                    push_command(c, 4'($urandom_range(15, 0)), $urandom);
                end
                left--;
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_length(5'd5);
        push_command(lps_pkg::CMD_IDENT, 4'd0, 0);
        hold_cycles = HOLD_CYCLES;
        repeat (6)
        begin
            push_command(lps_pkg::CMD_NEXT, 4'($urandom_range(15, 0)), $urandom);
            push_command(lps_pkg::CMD_PREV, 4'($urandom_range(15, 0)), $urandom);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        perm_beat_t b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat position %0d element %0d",
                                          position, element));
            end
            else
            begin
                b = pending_beats.pop_front();
                if (position !== b.position || element !== b.element ||
                    last !== b.last || advanced !== b.advanced)
                begin
                    report_mismatch($sformatf(
                        "got pos %0d elem %0d last %b adv %b, want pos %0d elem %0d last %b adv %b",
                        position, element, last, advanced,
                        b.position, b.element, b.last, b.advanced));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int p = 0; p < lps_pkg::MAX_LEN; p++)
        begin
            seq_model[p] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_and_extremes();
        test_length_corners();
        test_repeated_values();
        test_random_traffic(27, 70, 72);
        test_random_traffic(70, 27, 72);
        test_random_traffic(0, 0, 72);
        test_backpressure();
        wait_idle();
        if (pending_beats.size() != 0)
        begin
            report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));
        end
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/lps_ram.sv
hw/rtl/lps_ctrl.sv
hw/rtl/lexicographic_permutation_stepper_core.sv
hw/rtl/lps_chk.sv
sim/tb_lexicographic_permutation_stepper_core.sv
